// ===== src/dka_pkg.sv =====
package dka_pkg;

    localparam int NUM_DIRS   = 4;
    localparam int DIR_W      = 2;
    localparam int NOW_W      = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_INTERVAL = 8'd1;

    localparam logic [CFG_W-1:0] INITIAL_DELAY_RST   = 16'd300;
    localparam logic [CFG_W-1:0] REPEAT_INTERVAL_RST = 16'd100;

    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

    typedef struct packed {
        logic [NOW_W-1:0]    now_ms;
        logic [NUM_DIRS-1:0] pressed;
    } sample_t;

    typedef struct packed {
        logic [CFG_W-1:0] initial_delay_ms;
        logic [CFG_W-1:0] repeat_interval_ms;
    } cfg_t;

endpackage

// ===== src/direction_key_autorepeat_top.sv =====
// Direction key autorepeat.
// The slave stream takes one poll sample per item: four direction-held bits
// and a free-running millisecond timestamp. The master stream returns one
// item per sample with four pulse bits, one for each direction.
// A newly pressed direction pulses at once and becomes the active one; while
// it stays held it pulses again after initial_delay_ms and then every
// repeat_interval_ms, measured on the wrapping 32-bit timestamp.
// The configuration channel writes register 0 (initial delay) or register 1
// (repeat interval); other indexes are accepted and ignored. It is always
// ready, and is meant to be written while no samples are in flight.
// The result appears on the master side after its sample passes the input
// register and then the output register, which the decision logic feeds.
// Throughput is one item per cycle while the receiver does not stall; the key
// state is updated between samples on each advance.
// When the receiver stalls, the output register holds its item and the input
// register can still take one more sample, so s_axis_tready drops only when
// both are full. Reset clears all held flags, the timer and repeat mode, and
// loads the delays with 300 ms and 100 ms.
module direction_key_autorepeat_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // Bits from 0: up_pressed, down_pressed, left_pressed, right_pressed,
    // now_ms[31:0], zero padding.
    input  logic [dka_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // Bits from 0: up_pulse, down_pulse, left_pulse, right_pulse, zero padding.
    output logic [dka_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dka_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [dka_pkg::CFG_W-1:0]           cfg_data
);

    dka_pkg::cfg_t                cfg;
    logic                         in_valid_reg;
    logic                         in_valid_next;
    dka_pkg::sample_t             in_sample_reg;
    logic                         out_valid_reg;
    logic                         out_valid_next;
    logic [dka_pkg::NUM_DIRS-1:0] out_pulse_reg;
    logic [dka_pkg::NUM_DIRS-1:0] pulse;
    logic                         advance;
    logic                         in_accept;

    assign cfg_ready     = 1'b1;
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    dka_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    dka_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .sample  (in_sample_reg),
        .cfg     (cfg),
        .pulse   (pulse)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_sample_reg.pressed <= s_axis_tdata[dka_pkg::NUM_DIRS-1:0];
            in_sample_reg.now_ms  <= s_axis_tdata[dka_pkg::NUM_DIRS +: dka_pkg::NOW_W];
        end
        if (advance)
            out_pulse_reg <= pulse;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(dka_pkg::OUT_DATA_W - dka_pkg::NUM_DIRS){1'b0}}, out_pulse_reg};

`ifndef SYNTHESIS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !advance)
        else $error("output item overwritten while stalled");

    a_ready_when_room: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_axis_tready)
        else $error("input not ready with an empty input register");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item did not reach the output register");
`endif

endmodule

// ===== src/dka_cfg_regs.sv =====
module dka_cfg_regs
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [dka_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [dka_pkg::CFG_W-1:0]      wr_data,
    output dka_pkg::cfg_t                  cfg
);

    dka_pkg::cfg_t cfg_reg;
    dka_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                dka_pkg::REG_INITIAL_DELAY:   cfg_next.initial_delay_ms   = wr_data;
                dka_pkg::REG_REPEAT_INTERVAL: cfg_next.repeat_interval_ms = wr_data;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.initial_delay_ms   <= dka_pkg::INITIAL_DELAY_RST;
            cfg_reg.repeat_interval_ms <= dka_pkg::REPEAT_INTERVAL_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/dka_core.sv =====
module dka_core
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  dka_pkg::sample_t              sample,
    input  dka_pkg::cfg_t                 cfg,
    output logic [dka_pkg::NUM_DIRS-1:0]  pulse
);

    logic [dka_pkg::NUM_DIRS-1:0] held_reg;
    logic [dka_pkg::NUM_DIRS-1:0] held_next;
    logic [dka_pkg::DIR_W-1:0]    active_reg;
    logic [dka_pkg::DIR_W-1:0]    active_next;
    logic                         repeating_reg;
    logic                         repeating_next;
    logic [dka_pkg::NOW_W-1:0]    mark_reg;
    logic [dka_pkg::NOW_W-1:0]    mark_next;

    logic [dka_pkg::NUM_DIRS-1:0] new_press;
    logic [dka_pkg::NUM_DIRS-1:0] lower_mask;
    logic [dka_pkg::NOW_W-1:0]    elapsed;
    logic [dka_pkg::NOW_W-1:0]    limit;
    logic                         fire;
    logic [dka_pkg::DIR_W-1:0]    last_new;

    // A held active direction repeats only if no direction with a lower index
    // than the active one is newly pressed in this sample.
    always_comb
    begin
        new_press  = sample.pressed & ~held_reg;
        lower_mask = (dka_pkg::NUM_DIRS)'((1 << active_reg) - 1);
        elapsed    = sample.now_ms - mark_reg;
        limit      = repeating_reg ? {16'd0, cfg.repeat_interval_ms}
                                   : {16'd0, cfg.initial_delay_ms};
        fire       = held_reg[active_reg] && sample.pressed[active_reg]
                     && ((new_press & lower_mask) == '0) && (elapsed > limit);

        if (new_press[dka_pkg::DIR_RIGHT])
            last_new = dka_pkg::DIR_RIGHT;
        else if (new_press[dka_pkg::DIR_LEFT])
            last_new = dka_pkg::DIR_LEFT;
        else if (new_press[dka_pkg::DIR_DOWN])
            last_new = dka_pkg::DIR_DOWN;
        else
            last_new = dka_pkg::DIR_UP;

        pulse = new_press;
        if (fire)
            pulse[active_reg] = 1'b1;

        held_next      = sample.pressed;
        active_next    = active_reg;
        repeating_next = repeating_reg;
        mark_next      = mark_reg;
        if (new_press != '0)
        begin
            active_next    = last_new;
            repeating_next = 1'b0;
            mark_next      = sample.now_ms;
        end
        else if (fire)
        begin
            repeating_next = 1'b1;
            mark_next      = sample.now_ms;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg      <= '0;
            active_reg    <= dka_pkg::DIR_UP;
            repeating_reg <= 1'b0;
            mark_reg      <= '0;
        end
        else if (advance)
        begin
            held_reg      <= held_next;
            active_reg    <= active_next;
            repeating_reg <= repeating_next;
            mark_reg      <= mark_next;
        end
    end

`ifndef SYNTHESIS
    a_pulse_needs_press: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> ((pulse & ~sample.pressed) == '0))
        else $error("pulse on a direction that is not held");

    a_one_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> $onehot0(pulse & ~new_press))
        else $error("more than one repeat pulse in one sample");

    a_new_press_clears_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (new_press != '0)) |=> (!repeating_reg && (active_reg == $past(last_new))))
        else $error("new press did not restart the active direction");

    a_held_tracks_input: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (held_reg == $past(sample.pressed)))
        else $error("held flags do not follow the sample");
`endif

endmodule
